>>> design/bpa_pkg.sv
// bpa_pkg: shared types, codes and defaults for the buffer pool allocator
// no dependencies; used by bpa_ctrl, bpa_datapath and buffer_pool_allocator_core
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // default pool geometry
  localparam int MAX_BUFFERS = 64;
  localparam int MAX_ENTRIES = 4096;

  // register reset values
  localparam int RESET_BUFFERS = 64;
  localparam int RESET_ENTRIES = 4096;

  // configuration port geometry
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFERS_IN_USE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_PER_BUFFER = 4'd1;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_BAKE  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_STATE = 2'd3;

  // buffer conditions
  localparam logic [1:0] COND_VACANT = 2'd0;
  localparam logic [1:0] COND_MAPPED = 2'd1;
  localparam logic [1:0] COND_BAKED  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  buffer_index;
    logic [12:0] position;
    logic [31:0] index_value;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  allocated_buffer;
    logic [6:0]  buffers_left;
    logic        memory_write;
    logic [17:0] memory_address;
    logic [31:0] memory_value;
  } bpa_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch item, launch memory reads
    logic commit;    // update pool state, load result register
    logic cfg_write; // register write, re-initialize pool
  } bpa_cmd_t;

endpackage

`default_nettype wire

>>> design/bpa_ctrl.sv
// bpa_ctrl: two-state sequencer plus result handshake for the allocator
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  output bpa_pkg::bpa_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result register can take a new item when empty or draining
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = in_valid_i && (state_q == S_IDLE);
    cmd_o.commit    = (state_q == S_EXEC) && out_free;
    cmd_o.cfg_write = cfg_valid_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> design/bpa_datapath.sv
// bpa_datapath: config registers, vacant stack, condition memory, result register
// depends on bpa_pkg; driven by bpa_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath #(
  parameter int MaxBuffers = bpa_pkg::MAX_BUFFERS,
  parameter int MaxEntries = bpa_pkg::MAX_ENTRIES
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  bpa_pkg::bpa_cmd_t               cmd_i,
  input  bpa_pkg::bpa_in_t                in_i,
  input  wire [bpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [bpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bpa_pkg::bpa_out_t               out_o
);

  localparam int AW  = (MaxBuffers > 1) ? $clog2(MaxBuffers) : 1;
  localparam int NW  = $clog2(MaxBuffers + 1);
  localparam int EW  = $clog2(MaxEntries + 1);
  localparam int PW  = 8 + EW;
  localparam int RESET_POOL =
    (bpa_pkg::RESET_BUFFERS > MaxBuffers) ? MaxBuffers : bpa_pkg::RESET_BUFFERS;

  // configuration registers
  logic [6:0]  bufs_q, bufs_d;
  logic [12:0] ents_q, ents_d;
  logic        init_pool;

  // pool state
  logic [NW-1:0]         count_q, count_d;
  logic [NW-1:0]         low_q, low_d;    // lowest count since init
  logic [MaxBuffers-1:0] valid_q, valid_d;

  // storage
  logic [AW-1:0] stack_mem [MaxBuffers];
  logic [1:0]    cond_mem  [MaxBuffers];

  // captured item and read data
  bpa_pkg::bpa_in_t item_q;
  logic [AW-1:0]    stk_rd_q;
  logic [1:0]       cond_rd_q;
  logic [PW-1:0]    prod_q;

  // result register
  bpa_pkg::bpa_out_t out_q, res;

  logic [NW-1:0] pool_n, pool_n_next;
  logic [EW-1:0] ent_n;
  logic [AW-1:0] bi_idx, top_buf;
  logic          bi_ok, pos_ok;
  logic [1:0]    cond;
  logic          cond_we, stk_we;
  logic [AW-1:0] cond_wa;
  logic [1:0]    cond_wd;

  // saturated pool size and entry count
  assign pool_n = (32'(bufs_q) > 32'(MaxBuffers)) ? NW'(MaxBuffers) : NW'(bufs_q);
  assign ent_n  = (32'(ents_q) > 32'(MaxEntries)) ? EW'(MaxEntries) : EW'(ents_q);
  assign pool_n_next = (32'(bufs_d) > 32'(MaxBuffers)) ? NW'(MaxBuffers) : NW'(bufs_d);

  // register writes; an unknown index changes nothing
  always_comb begin
    bufs_d    = bufs_q;
    ents_d    = ents_q;
    init_pool = 1'b0;
    if (cmd_i.cfg_write) begin
      case (cfg_index_i)
        bpa_pkg::REG_BUFFERS_IN_USE: begin
          bufs_d    = cfg_data_i[6:0];
          init_pool = 1'b1;
        end
        bpa_pkg::REG_ENTRIES_PER_BUFFER: begin
          ents_d    = cfg_data_i[12:0];
          init_pool = 1'b1;
        end
        default: init_pool = 1'b0;
      endcase
    end
  end

  // item checks
  assign bi_idx = item_q.buffer_index[AW-1:0];
  assign bi_ok  = 32'(item_q.buffer_index) < 32'(pool_n);
  assign pos_ok = 32'(item_q.position) < 32'(ent_n);
  assign cond   = valid_q[bi_idx] ? cond_rd_q : bpa_pkg::COND_VACANT;

  // top of stack: an untouched slot takes its init value, pool size minus count
  assign top_buf = (low_q == count_q) ? AW'(pool_n - count_q) : stk_rd_q;

  // operation execute
  always_comb begin
    res                  = '0;
    count_d              = count_q;
    low_d                = low_q;
    valid_d              = valid_q;
    cond_we              = 1'b0;
    cond_wa              = bi_idx;
    cond_wd              = bpa_pkg::COND_VACANT;
    stk_we               = 1'b0;
    res.status           = bpa_pkg::ST_DONE;
    case (item_q.operation)
      bpa_pkg::OP_ALLOC: begin
        if (count_q == '0) begin
          res.status = bpa_pkg::ST_EMPTY;
        end else begin
          count_d              = count_q - 1'b1;
          if (count_d < low_q) low_d = count_d;
          cond_we              = 1'b1;
          cond_wa              = top_buf;
          cond_wd              = bpa_pkg::COND_MAPPED;
          res.allocated_buffer = 6'(top_buf);
        end
      end
      bpa_pkg::OP_FREE: begin
        if (!bi_ok) begin
          res.status = bpa_pkg::ST_RANGE;
        end else if (cond == bpa_pkg::COND_VACANT) begin
          res.status = bpa_pkg::ST_STATE;
        end else begin
          cond_we = 1'b1;
          cond_wd = bpa_pkg::COND_VACANT;
          if (32'(count_q) < 32'(MaxBuffers)) begin
            stk_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      bpa_pkg::OP_BAKE: begin
        if (!bi_ok) begin
          res.status = bpa_pkg::ST_RANGE;
        end else if (cond != bpa_pkg::COND_MAPPED) begin
          res.status = bpa_pkg::ST_STATE;
        end else begin
          cond_we = 1'b1;
          cond_wd = bpa_pkg::COND_BAKED;
        end
      end
      bpa_pkg::OP_WRITE: begin
        if (!pos_ok || !bi_ok) begin
          res.status = bpa_pkg::ST_RANGE;
        end else if (cond != bpa_pkg::COND_MAPPED) begin
          res.status = bpa_pkg::ST_STATE;
        end else begin
          res.memory_write   = 1'b1;
          res.memory_address = 18'(32'(prod_q) + 32'(item_q.position));
          res.memory_value   = item_q.index_value;
        end
      end
      default: res.status = bpa_pkg::ST_DONE;
    endcase
    if (cond_we) valid_d[cond_wa] = 1'b1;
    res.buffers_left = 7'(count_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bufs_q  <= 7'(bpa_pkg::RESET_BUFFERS);
      ents_q  <= 13'(bpa_pkg::RESET_ENTRIES);
      count_q <= NW'(RESET_POOL);
      low_q   <= NW'(RESET_POOL);
      valid_q <= '0;
    end else begin
      bufs_q <= bufs_d;
      ents_q <= ents_d;
      if (init_pool) begin
        count_q <= pool_n_next;
        low_q   <= pool_n_next;
        valid_q <= '0;
      end else if (cmd_i.commit) begin
        count_q <= count_d;
        low_q   <= low_d;
        valid_q <= valid_d;
      end
    end
  end

  // item capture, memory reads and address product
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q    <= in_i;
      stk_rd_q  <= stack_mem[AW'(count_q - 1'b1)];
      cond_rd_q <= cond_mem[in_i.buffer_index[AW-1:0]];
      prod_q    <= PW'(in_i.buffer_index) * PW'(ent_n);
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && cond_we) begin
      cond_mem[cond_wa] <= cond_wd;
    end
    if (cmd_i.commit && stk_we) begin
      stack_mem[AW'(count_q)] <= bi_idx;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

>>> design/buffer_pool_allocator_core.sv
// buffer_pool_allocator_core: top level of the buffer pool allocator
// instantiates bpa_ctrl and bpa_datapath; depends on bpa_pkg
// an accepted item is captured with its memory reads, then executed
// into the output register once it is free; only then is a new item taken
// reset: registers return to 64 buffers and 4096 entries, all buffers vacant
// a register write re-initializes the pool in the same cycle
`timescale 1ns / 1ps
`default_nettype none

module buffer_pool_allocator_core #(
  parameter int MaxBuffers = bpa_pkg::MAX_BUFFERS,
  parameter int MaxEntries = bpa_pkg::MAX_ENTRIES
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  bpa_pkg::bpa_in_t              in_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output bpa_pkg::bpa_out_t             out_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [bpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [bpa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bpa_pkg::bpa_cmd_t cmd;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // pool state and result
  bpa_datapath #(
    .MaxBuffers (MaxBuffers),
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
